// ----- rtl/bps_pkg.sv -----
package bps_pkg;

  localparam int unsigned TimerBits = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef logic [TimerBits-1:0] timer_t;

  typedef enum logic [2:0] {
    ST_OFF       = 3'd0,
    ST_BOOTING   = 3'd1,
    ST_BOARD_ON  = 3'd2,
    ST_ON        = 3'd3,
    ST_SLEEPING  = 3'd4,
    ST_SHUTTING  = 3'd5,
    ST_BOARD_OFF = 3'd6
  } pwr_state_e;

  typedef enum logic [1:0] {
    LED_OFF    = 2'd0,
    LED_STEADY = 2'd1,
    LED_PULSE  = 2'd2
  } led_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WARMUP     = 2'd0,
    CFG_PULSE      = 2'd1,
    CFG_LONG_PRESS = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] CmdOn       = 8'h00;
  localparam logic [7:0] CmdShutdown = 8'hFF;
  localparam logic [7:0] CmdSleep    = 8'h20;

  localparam logic [CfgDataW-1:0] WarmupReset    = 16'd500;
  localparam logic [CfgDataW-1:0] PulseReset     = 16'd200;
  localparam logic [CfgDataW-1:0] LongPressReset = 16'd5000;

  typedef struct packed {
    logic       button_pressed;
    logic       rail_powered;
    logic       command_valid;
    logic [7:0] command_byte;
  } in_beat_t;

  typedef struct packed {
    logic       supply_on;
    logic       board_button;
    logic [1:0] led_mode;
    logic [2:0] power_state;
  } out_beat_t;

  typedef struct packed {
    logic [CfgDataW-1:0] warmup_ticks;
    logic [CfgDataW-1:0] pulse_ticks;
    logic [CfgDataW-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    pwr_state_e sys_state;
    logic       press_handled;
    logic       prev_pressed;
    timer_t     press_timer;
    logic       pulse_active;
    timer_t     pulse_timer;
    logic       warmup_active;
    timer_t     warmup_timer;
    logic       supply;
    logic       button;
  } seq_state_t;

  function automatic timer_t timer_inc(timer_t t);
    return (t == '1) ? t : t + timer_t'(1);
  endfunction

  function automatic logic is_running(pwr_state_e s);
    return (s == ST_BOARD_ON) || (s == ST_ON) || (s == ST_SLEEPING) || (s == ST_SHUTTING);
  endfunction

endpackage

// ----- rtl/bps_cfg_regs.sv -----
module bps_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0]  cfg_data_i,
  output bps_pkg::cfg_t                 cfg_o
);

  bps_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bps_pkg::CFG_WARMUP:     cfg_d.warmup_ticks     = cfg_data_i;
        bps_pkg::CFG_PULSE:      cfg_d.pulse_ticks      = cfg_data_i;
        bps_pkg::CFG_LONG_PRESS: cfg_d.long_press_ticks = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warmup_ticks     <= bps_pkg::WarmupReset;
      cfg_q.pulse_ticks      <= bps_pkg::PulseReset;
      cfg_q.long_press_ticks <= bps_pkg::LongPressReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/bps_step.sv -----
module bps_step (
  input  bps_pkg::cfg_t       cfg_i,
  input  bps_pkg::seq_state_t cur_i,
  input  bps_pkg::in_beat_t   beat_i,
  output bps_pkg::seq_state_t nxt_o,
  output bps_pkg::out_beat_t  res_o
);

  always_comb begin
    bps_pkg::seq_state_t n;
    bps_pkg::pwr_state_e shown;
    bps_pkg::led_mode_e  led;
    logic                btn;

    n   = cur_i;
    btn = beat_i.button_pressed;

    // generated button pulse
    if (n.pulse_active) begin
      n.pulse_timer = bps_pkg::timer_inc(n.pulse_timer);
      if (n.pulse_timer >= cfg_i.pulse_ticks) begin
        n.button       = 1'b0;
        n.pulse_active = 1'b0;
      end
    end

    // warmup after supply on
    if (n.warmup_active) begin
      n.warmup_timer = bps_pkg::timer_inc(n.warmup_timer);
      if (n.warmup_timer >= cfg_i.warmup_ticks) begin
        n.pulse_active  = 1'b1;
        n.pulse_timer   = '0;
        n.button        = 1'b1;
        n.warmup_active = 1'b0;
      end
    end

    // rail tracking
    if (!beat_i.rail_powered && bps_pkg::is_running(n.sys_state)) begin
      n.sys_state = bps_pkg::ST_BOARD_OFF;
    end
    if (beat_i.rail_powered && (n.sys_state == bps_pkg::ST_BOOTING)) begin
      n.sys_state = bps_pkg::ST_BOARD_ON;
    end

    // front button
    if (btn && !n.prev_pressed) begin
      n.press_timer   = '0;
      n.press_handled = 1'b0;
    end else begin
      n.press_timer = bps_pkg::timer_inc(n.press_timer);
      if (!btn && n.prev_pressed) begin
        n.press_handled = 1'b0;
      end
    end
    n.prev_pressed = btn;

    if (btn && (n.press_timer >= cfg_i.long_press_ticks)) begin
      n.press_handled = 1'b1;
      n.button        = 1'b0;
      n.pulse_active  = 1'b0;
      n.warmup_active = 1'b0;
      n.supply        = 1'b0;
      n.sys_state     = bps_pkg::ST_OFF;
    end else if (!n.press_handled) begin
      if (!bps_pkg::is_running(n.sys_state)) begin
        if ((n.sys_state == bps_pkg::ST_OFF) && btn) begin
          n.supply        = 1'b1;
          n.warmup_timer  = '0;
          n.warmup_active = 1'b1;
          n.sys_state     = bps_pkg::ST_BOOTING;
          n.press_handled = 1'b1;
        end
      end else if (!n.pulse_active) begin
        n.button = btn;
      end
    end

    // host command
    if (beat_i.command_valid && bps_pkg::is_running(n.sys_state)) begin
      case (beat_i.command_byte)
        bps_pkg::CmdOn:       n.sys_state = bps_pkg::ST_ON;
        bps_pkg::CmdShutdown: n.sys_state = bps_pkg::ST_SHUTTING;
        bps_pkg::CmdSleep:    n.sys_state = bps_pkg::ST_SLEEPING;
        default: ;
      endcase
    end

    shown = n.sys_state;
    case (shown)
      bps_pkg::ST_OFF: led = bps_pkg::LED_OFF;
      bps_pkg::ST_ON:  led = bps_pkg::LED_STEADY;
      default:         led = bps_pkg::LED_PULSE;
    endcase

    // final power down
    if (n.sys_state == bps_pkg::ST_BOARD_OFF) begin
      n.supply    = 1'b0;
      n.sys_state = bps_pkg::ST_OFF;
    end

    nxt_o              = n;
    res_o.supply_on    = n.supply;
    res_o.board_button = n.button;
    res_o.led_mode     = led;
    res_o.power_state  = shown;
  end

endmodule

// ----- rtl/board_power_sequencer_unit.sv -----
// Board power sequencer: one tick beat in, one status beat out. A tick beat is
// captured in an input register and evaluated against the sequencer state on
// its way to the result register, so a new beat is taken every clock cycle
// while the output is not stalled, and its result is held in the result
// register and offered until it is taken. The result register and the input
// register together let the unit keep accepting one beat while a finished
// result waits. Configuration writes are always accepted and must only be
// issued while no beat is in flight.
module board_power_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bps_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bps_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bps_pkg::CfgDataW-1:0]  cfg_data_i
);

  bps_pkg::cfg_t       cfg;
  bps_pkg::seq_state_t state_q, state_d;
  bps_pkg::in_beat_t   in_q;
  bps_pkg::out_beat_t  res_q, res_d;
  logic                in_valid_q;
  logic                out_valid_q;
  logic                advance;

  bps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bps_step u_step (
    .cfg_i  (cfg),
    .cur_i  (state_q),
    .beat_i (in_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // board off is shown with the supply already dropped
  a_board_off_supply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.power_state == bps_pkg::ST_BOARD_OFF) |-> !out_data_o.supply_on)
    else $error("board off beat with supply on");

  // board off never persists in the stored state
  a_no_stored_board_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.sys_state != bps_pkg::ST_BOARD_OFF)
    else $error("stored state is board off");

  // input only stalls when both stages are full and output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned LongHoldOff   = 300;
  localparam logic [bps_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  logic clk;
  logic rst_n;

  logic in_valid;
  logic in_ready;
  bps_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  bps_pkg::out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [bps_pkg::CfgIdxW-1:0] cfg_index;
  logic [bps_pkg::CfgDataW-1:0] cfg_data;

  board_power_sequencer_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sequencer prediction state
  logic [bps_pkg::CfgDataW-1:0] warmup_len;
  logic [bps_pkg::CfgDataW-1:0] pulse_len;
  logic [bps_pkg::CfgDataW-1:0] long_press_len;

  bps_pkg::pwr_state_e seq_st;
  logic press_done;
  logic btn_last;
  logic [bps_pkg::TimerBits-1:0] hold_cnt;
  logic pulse_busy;
  logic [bps_pkg::TimerBits-1:0] pulse_cnt;
  logic warm_busy;
  logic [bps_pkg::TimerBits-1:0] warm_cnt;
  logic supply_q;
  logic button_q;

  bps_pkg::out_beat_t pending_status[$];
  int unsigned error_count;
  int unsigned idle_run;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_off;

  function automatic logic [bps_pkg::TimerBits-1:0] count_up_sat(
      logic [bps_pkg::TimerBits-1:0] t);
    return (&t) ? t : t + bps_pkg::TimerBits'(1);
  endfunction

  function automatic logic is_live_state(bps_pkg::pwr_state_e s);
    return (s == bps_pkg::ST_BOARD_ON) || (s == bps_pkg::ST_ON) ||
           (s == bps_pkg::ST_SLEEPING) || (s == bps_pkg::ST_SHUTTING);
  endfunction

  function automatic bps_pkg::out_beat_t next_status(bps_pkg::in_beat_t b);
    bps_pkg::out_beat_t r;
    bps_pkg::pwr_state_e shown;
    if (pulse_busy) begin
      pulse_cnt = count_up_sat(pulse_cnt);
      if (pulse_cnt >= pulse_len) begin
        button_q = 1'b0;
        pulse_busy = 1'b0;
      end
    end
    if (warm_busy) begin
      warm_cnt = count_up_sat(warm_cnt);
      if (warm_cnt >= warmup_len) begin
        pulse_busy = 1'b1;
        pulse_cnt = '0;
        button_q = 1'b1;
        warm_busy = 1'b0;
      end
    end
    if (!b.rail_powered && is_live_state(seq_st)) seq_st = bps_pkg::ST_BOARD_OFF;
    if (b.rail_powered && seq_st == bps_pkg::ST_BOOTING) seq_st = bps_pkg::ST_BOARD_ON;
    if (b.button_pressed && !btn_last) begin
      hold_cnt = '0;
      press_done = 1'b0;
    end else begin
      hold_cnt = count_up_sat(hold_cnt);
      if (!b.button_pressed && btn_last) press_done = 1'b0;
    end
    btn_last = b.button_pressed;
    if (b.button_pressed && hold_cnt >= long_press_len) begin
      press_done = 1'b1;
      button_q = 1'b0;
      pulse_busy = 1'b0;
      warm_busy = 1'b0;
      supply_q = 1'b0;
      seq_st = bps_pkg::ST_OFF;
    end else if (!press_done) begin
      if (!is_live_state(seq_st)) begin
        if (seq_st == bps_pkg::ST_OFF && b.button_pressed) begin
          supply_q = 1'b1;
          warm_cnt = '0;
          warm_busy = 1'b1;
          seq_st = bps_pkg::ST_BOOTING;
          press_done = 1'b1;
        end
      end else if (!pulse_busy) begin
        button_q = b.button_pressed;
      end
    end
    if (b.command_valid && is_live_state(seq_st)) begin
      case (b.command_byte)
        bps_pkg::CmdOn: seq_st = bps_pkg::ST_ON;
        bps_pkg::CmdShutdown: seq_st = bps_pkg::ST_SHUTTING;
        bps_pkg::CmdSleep: seq_st = bps_pkg::ST_SLEEPING;
        default: ;
      endcase
    end
    shown = seq_st;
    if (seq_st == bps_pkg::ST_OFF) r.led_mode = bps_pkg::LED_OFF;
    else if (seq_st == bps_pkg::ST_ON) r.led_mode = bps_pkg::LED_STEADY;
    else r.led_mode = bps_pkg::LED_PULSE;
    if (seq_st == bps_pkg::ST_BOARD_OFF) begin
      supply_q = 1'b0;
      seq_st = bps_pkg::ST_OFF;
    end
    r.supply_on = supply_q;
    r.board_button = button_q;
    r.power_state = shown;
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected beat: supply %0b button %0b led %0d state %0d",
                   out_data.supply_on, out_data.board_button, out_data.led_mode,
                   out_data.power_state);
      end else begin
        if (out_data.supply_on !== pending_status[0].supply_on ||
            out_data.board_button !== pending_status[0].board_button ||
            out_data.led_mode !== pending_status[0].led_mode ||
            out_data.power_state !== pending_status[0].power_state) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected supply %0b button %0b led %0d state %0d, got %s",
                     pending_status[0].supply_on, pending_status[0].board_button,
                     pending_status[0].led_mode, pending_status[0].power_state,
                     $sformatf("supply %0b button %0b led %0d state %0d",
                               out_data.supply_on, out_data.board_button,
                               out_data.led_mode, out_data.power_state));
        end
        void'(pending_status.pop_front());
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_off != 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_tick(bps_pkg::in_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(next_status(b));
  endtask

  task automatic tick(logic btn, logic rail, logic cv, logic [7:0] cmd);
    bps_pkg::in_beat_t b;
    b.button_pressed = btn;
    b.rail_powered = rail;
    b.command_valid = cv;
    b.command_byte = cmd;
    send_tick(b);
  endtask

  task automatic wait_all_status();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bps_pkg::CfgIdxW-1:0] idx,
                           logic [bps_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bps_pkg::CFG_WARMUP: warmup_len = val;
      bps_pkg::CFG_PULSE: pulse_len = val;
      bps_pkg::CFG_LONG_PRESS: long_press_len = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_timing(logic [bps_pkg::CfgDataW-1:0] w,
                              logic [bps_pkg::CfgDataW-1:0] p,
                              logic [bps_pkg::CfgDataW-1:0] l);
    write_reg(bps_pkg::CFG_WARMUP, w);
    write_reg(bps_pkg::CFG_PULSE, p);
    write_reg(bps_pkg::CFG_LONG_PRESS, l);
  endtask

  // button and rail in runs, so boots, pulses and long presses happen
  task automatic run_sessions(int unsigned n);
    bps_pkg::in_beat_t b;
    int unsigned i;
    int unsigned btn_run;
    int unsigned rail_run;
    int unsigned pick;
    logic btn_lvl;
    logic rail_lvl;
    btn_run = 0;
    rail_run = $urandom_range(60, 5);
    btn_lvl = 1'b0;
    rail_lvl = 1'b1;
    for (i = 0; i < n; i++) begin
      if (btn_run == 0) begin
        btn_lvl = !btn_lvl;
        if (btn_lvl)
          btn_run = ($urandom_range(5) == 0) ? $urandom_range(60, 15) : $urandom_range(4, 1);
        else
          btn_run = $urandom_range(25, 1);
      end
      if (rail_run == 0) begin
        rail_lvl = !rail_lvl;
        rail_run = rail_lvl ? $urandom_range(80, 5) : $urandom_range(6, 1);
      end
      btn_run--;
      rail_run--;
      b.button_pressed = btn_lvl;
      b.rail_powered = rail_lvl;
      b.command_valid = ($urandom_range(4) == 0);
      pick = $urandom_range(3);
      case (pick)
        0: b.command_byte = bps_pkg::CmdOn;
        1: b.command_byte = bps_pkg::CmdShutdown;
        2: b.command_byte = bps_pkg::CmdSleep;
        default: b.command_byte = 8'($urandom_range(255));
      endcase
      if ($urandom_range(9) == 0) b = bps_pkg::in_beat_t'($urandom());
      send_tick(b);
    end
  endtask

  task automatic test_directed();
    write_timing(16'd2, 16'd2, 16'd5);
    tick(1'b0, 1'b0, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b1, bps_pkg::CmdOn);
    tick(1'b1, 1'b0, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b0, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b1, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b1, bps_pkg::CmdSleep);
    tick(1'b1, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b1, bps_pkg::CmdShutdown);
    tick(1'b0, 1'b1, 1'b1, 8'h55);
    tick(1'b0, 1'b1, 1'b1, bps_pkg::CmdOn);
    tick(1'b0, 1'b0, 1'b1, bps_pkg::CmdOn);
    tick(1'b0, 1'b0, 1'b0, bps_pkg::CmdOn);
    repeat (8) tick(1'b1, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b1, 1'b1, 1'b1, 8'hFF);
    tick(1'b1, 1'b1, 1'b1, bps_pkg::CmdSleep);
    wait_all_status();
  endtask

  task automatic test_zero_timing();
    write_timing(16'd0, 16'd0, 16'd5);
    tick(1'b0, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b1, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b0, bps_pkg::CmdOn);
    wait_all_status();
    write_reg(bps_pkg::CFG_LONG_PRESS, 16'd0);
    tick(1'b1, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b1, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b0, 1'b1, 1'b0, bps_pkg::CmdOn);
    tick(1'b1, 1'b1, 1'b1, bps_pkg::CmdOn);
    wait_all_status();
  endtask

  task automatic test_idle_mix();
    int unsigned m;
    for (m = 0; m < 4; m++) begin
      case (m)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
      endcase
      write_timing(16'($urandom_range(15)), 16'($urandom_range(8)),
                   16'($urandom_range(40, 6)));
      run_sessions(190);
      wait_all_status();
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_timing(16'd4, 16'd3, 16'd12);
    hold_off = LongHoldOff;
    run_sessions(30);
    wait_all_status();
    run_sessions(30);
    wait_all_status();
  endtask

  task automatic test_extremes();
    write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CfgUnused, 16'h0000);
    run_sessions(40);
    wait_all_status();
    write_timing(16'd0, 16'd0, 16'd1);
    run_sessions(40);
    wait_all_status();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    idle_run = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off = 0;
    warmup_len = bps_pkg::WarmupReset;
    pulse_len = bps_pkg::PulseReset;
    long_press_len = bps_pkg::LongPressReset;
    seq_st = bps_pkg::ST_OFF;
    press_done = 1'b0;
    btn_last = 1'b0;
    hold_cnt = '0;
    pulse_busy = 1'b0;
    pulse_cnt = '0;
    warm_busy = 1'b0;
    warm_cnt = '0;
    supply_q = 1'b0;
    button_q = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_zero_timing();
    test_idle_mix();
    test_backpressure();
    test_extremes();

    wait_all_status();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
